>>> design/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants of the palette range rotator
// Action codes, register map, color widths and the control word that is
// broadcast to every palette cell.
// ----------------------------------------------------------------------------
package prr_pkg;

   localparam int ColorWidth = 8;
   localparam int EntryBytes = 3;
   localparam int EntryWidth = ColorWidth * EntryBytes;
   localparam int IndexWidth = 8;
   localparam int CountWidth = 9;
   localparam int AddrWidth  = 4;
   localparam int DataWidth  = 32;

   localparam logic [CountWidth-1:0] MinSpinColors = 9'd16;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_SPIN  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      REG_COLOR_COUNT = 2'd0,
      REG_CYCLE_LOW   = 2'd1,
      REG_CYCLE_HIGH  = 2'd2,
      REG_TC_LOCK     = 2'd3
   } reg_index_type;

   typedef logic [EntryWidth-1:0] entry_type;

   // control word seen by every cell in the row
   typedef struct packed {
      logic                  wr_en;
      logic [IndexWidth-1:0] wr_index;
      entry_type             wr_data;
      logic                  shift_down;  // entries move toward lower indices
      logic                  shift_up;    // entries move toward higher indices
      logic [IndexWidth-1:0] range_low;
      logic [IndexWidth-1:0] range_top;
   } cell_ctrl_type;

endpackage

>>> design/prr_if.sv
// ----------------------------------------------------------------------------
// prr_req_if / prr_rsp_if: valid/ready channels of the palette range rotator
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface prr_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [7:0]        entry_index;
   logic [7:0]        red_in;
   logic [7:0]        green_in;
   logic [7:0]        blue_in;
   logic signed [1:0] direction;
   logic [7:0]        step_count;

   modport source (output valid, action, entry_index, red_in, green_in, blue_in,
                   direction, step_count, input ready);
   modport sink   (input valid, action, entry_index, red_in, green_in, blue_in,
                   direction, step_count, output ready);
endinterface

interface prr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       palette_pushed;

   modport source (output valid, red_out, green_out, blue_out, palette_pushed,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, palette_pushed,
                   output ready);
endinterface

>>> design/prr_cell.sv
// ----------------------------------------------------------------------------
// prr_cell: one palette entry in the rotating row
// Holds a 24-bit entry; takes a write, or its neighbor's entry during a
// rotation step, or the wrapped entry at the range edge.
// ----------------------------------------------------------------------------
module prr_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  prr_pkg::cell_ctrl_type ctrl,
   input  prr_pkg::entry_type    lower_entry,
   input  prr_pkg::entry_type    upper_entry,
   input  prr_pkg::entry_type    wrap_entry,
   output prr_pkg::entry_type    entry
);
   import prr_pkg::*;

   localparam logic [IndexWidth-1:0] MyIndex = IndexWidth'(CELL_INDEX);

   entry_type entry_ff;
   entry_type entry_in;
   logic      in_range;

   assign in_range = (MyIndex >= ctrl.range_low) && (MyIndex <= ctrl.range_top);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.wr_en && ctrl.wr_index == MyIndex) begin
         entry_in = ctrl.wr_data;
      end else if (ctrl.shift_down && in_range) begin
         entry_in = (MyIndex == ctrl.range_top) ? wrap_entry : upper_entry;
      end else if (ctrl.shift_up && in_range) begin
         entry_in = (MyIndex == ctrl.range_low) ? wrap_entry : lower_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> design/prr_csr.sv
// ----------------------------------------------------------------------------
// prr_csr: APB-style register file of the palette range rotator
// Color count, cycling range bounds and the true-color lock.
// ----------------------------------------------------------------------------
module prr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [prr_pkg::AddrWidth-1:0] paddr,
   input  logic [prr_pkg::DataWidth-1:0] pwdata,
   output logic [prr_pkg::DataWidth-1:0] prdata,
   output logic                          pready,
   output logic [prr_pkg::CountWidth-1:0] color_count,
   output logic [prr_pkg::IndexWidth-1:0] cycle_low,
   output logic [prr_pkg::IndexWidth-1:0] cycle_high,
   output logic                          true_color_lock
);
   import prr_pkg::*;

   logic [CountWidth-1:0] color_count_ff;
   logic [IndexWidth-1:0] cycle_low_ff;
   logic [IndexWidth-1:0] cycle_high_ff;
   logic                  tc_lock_ff;
   logic                  wr_fire;
   reg_index_type         reg_sel;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite;
   assign reg_sel = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         color_count_ff <= 9'd256;
         cycle_low_ff   <= 8'd1;
         cycle_high_ff  <= 8'd255;
         tc_lock_ff     <= 1'b0;
      end else if (wr_fire) begin
         case (reg_sel)
            REG_COLOR_COUNT: color_count_ff <= pwdata[CountWidth-1:0];
            REG_CYCLE_LOW:   cycle_low_ff   <= pwdata[IndexWidth-1:0];
            REG_CYCLE_HIGH:  cycle_high_ff  <= pwdata[IndexWidth-1:0];
            REG_TC_LOCK:     tc_lock_ff     <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_COLOR_COUNT: prdata = DataWidth'(color_count_ff);
         REG_CYCLE_LOW:   prdata = DataWidth'(cycle_low_ff);
         REG_CYCLE_HIGH:  prdata = DataWidth'(cycle_high_ff);
         REG_TC_LOCK:     prdata = DataWidth'(tc_lock_ff);
         default:         prdata = '0;
      endcase
   end

   assign color_count     = color_count_ff;
   assign cycle_low       = cycle_low_ff;
   assign cycle_high      = cycle_high_ff;
   assign true_color_lock = tc_lock_ff;

endmodule

>>> design/palette_range_rotator.sv
// ----------------------------------------------------------------------------
// palette_range_rotator: RGB palette with color-cycling spins
// A row of palette cells; a spin shifts the cycling range one place a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one word per item: write an entry, read an entry, or spin.
//   rsp  - exactly one word per item: read components (zero otherwise) and
//          palette_pushed, set when a spin passes the count and lock checks.
//   APB  - color_count @0x0, cycle_low @0x4, cycle_high @0x8,
//          true_color_lock @0xC. Write only while the block is idle.
// Response: the response word is registered at acceptance, for every action;
//   a write enters its cell and a read its entry at that same edge.
// Spin: a spin that rotates holds req.ready low while the cell row performs
//   step_count single-place rotations of the whole range (up to 255), one
//   per cycle (the cell row shifts once per clock); its response word is
//   already out while the row is still turning.
// Reset: control and registers return to their defaults; palette contents
//   are undefined until written.
// Stall: while rsp is held off, the response register keeps its word and
//   req.ready stays low until that word is taken.
// ----------------------------------------------------------------------------
module palette_range_rotator #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   prr_req_if.sink                        req,
   prr_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [prr_pkg::AddrWidth-1:0]  paddr,
   input  logic [prr_pkg::DataWidth-1:0]  pwdata,
   output logic [prr_pkg::DataWidth-1:0]  prdata,
   output logic                           pready
);
   import prr_pkg::*;

   localparam int SelWidth = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [CountWidth-1:0] TopMax = CountWidth'(PALETTE_ENTRIES - 1);
   localparam logic [CountWidth-1:0] Entries = CountWidth'(PALETTE_ENTRIES);

   typedef enum logic {
      ST_IDLE,
      ST_SPIN
   } state_type;

   // configuration
   logic [CountWidth-1:0] color_count;
   logic [IndexWidth-1:0] cycle_low;
   logic [IndexWidth-1:0] cycle_high;
   logic                  true_color_lock;

   prr_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .color_count     (color_count),
      .cycle_low       (cycle_low),
      .cycle_high      (cycle_high),
      .true_color_lock (true_color_lock)
   );

   // control state
   state_type             state_ff;
   logic [IndexWidth-1:0] steps_ff;
   logic [IndexWidth-1:0] range_low_ff;
   logic [IndexWidth-1:0] range_top_ff;
   logic                  down_ff;
   logic [IndexWidth-1:0] wrap_index_ff;
   logic                  rsp_valid_ff;
   logic [ColorWidth-1:0] red_ff, green_ff, blue_ff;
   logic                  pushed_ff;

   logic                  req_accept;
   action_type            act;
   logic                  spin_ok;
   logic [CountWidth-1:0] low_ext, high_ext;
   logic [CountWidth-1:0] top_raw, top_clamped;
   logic                  rotate;
   logic                  index_valid;
   logic [IndexWidth-1:0] read_index;
   logic [SelWidth-1:0]   read_sel;
   entry_type             read_entry;
   cell_ctrl_type         cell_ctrl;
   entry_type             cell_entry [PALETTE_ENTRIES];

   assign act        = action_type'(req.action);
   assign req.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_accept = req.valid && req.ready;

   // spin decision, taken at acceptance from the current configuration
   assign low_ext     = CountWidth'(cycle_low);
   assign high_ext    = CountWidth'(cycle_high);
   assign spin_ok     = (color_count >= MinSpinColors) && !true_color_lock;
   assign top_raw     = (high_ext > color_count) ? (color_count - 9'd1) : high_ext;
   assign top_clamped = (top_raw > TopMax) ? TopMax : top_raw;
   // lo < top also keeps lo inside the store
   assign rotate = spin_ok && (req.direction != 2'sd0) && (low_ext < color_count) &&
                   (low_ext < high_ext) && (low_ext < top_clamped) &&
                   (req.step_count != '0);

   // one read port into the row: the request index when idle, the entry
   // that wraps around the range edge while spinning
   assign read_index  = (state_ff == ST_SPIN) ? wrap_index_ff : req.entry_index;
   assign index_valid = CountWidth'(req.entry_index) < Entries;
   assign read_sel    = read_index[SelWidth-1:0];
   assign read_entry  = cell_entry[read_sel];

   always_comb begin
      cell_ctrl            = '0;
      cell_ctrl.wr_en      = req_accept && (act == ACT_WRITE) && index_valid;
      cell_ctrl.wr_index   = req.entry_index;
      cell_ctrl.wr_data    = {req.red_in, req.green_in, req.blue_in};
      cell_ctrl.shift_down = (state_ff == ST_SPIN) && down_ff;
      cell_ctrl.shift_up   = (state_ff == ST_SPIN) && !down_ff;
      cell_ctrl.range_low  = range_low_ff;
      cell_ctrl.range_top  = range_top_ff;
   end

   // the row of cells, each wired to its two neighbors (an end cell takes the read port entry instead)
   for (genvar gi = 0; gi < PALETTE_ENTRIES; gi++) begin : g_cell
      entry_type lower_nb, upper_nb;
      if (gi == 0) begin : g_first
         assign lower_nb = read_entry;
      end else begin : g_lower
         assign lower_nb = cell_entry[gi-1];
      end
      if (gi == PALETTE_ENTRIES - 1) begin : g_last
         assign upper_nb = read_entry;
      end else begin : g_upper
         assign upper_nb = cell_entry[gi+1];
      end
      prr_cell #(
         .CELL_INDEX (gi)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .lower_entry (lower_nb),
         .upper_entry (upper_nb),
         .wrap_entry  (read_entry),
         .entry       (cell_entry[gi])
      );
   end

   // sequencer and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && act == ACT_SPIN && rotate) begin
                  state_ff <= ST_SPIN;
                  steps_ff <= req.step_count;
               end
            end
            ST_SPIN: begin
               steps_ff <= steps_ff - 8'd1;
               if (steps_ff == 8'd1) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // range latched at spin start: later config writes cannot disturb it
   always_ff @(posedge clock) begin
      if (req_accept && act == ACT_SPIN) begin
         range_low_ff  <= cycle_low;
         range_top_ff  <= top_clamped[IndexWidth-1:0];
         down_ff       <= (req.direction == 2'sd1);
         wrap_index_ff <= (req.direction == 2'sd1) ? cycle_low
                                                   : top_clamped[IndexWidth-1:0];
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         red_ff    <= '0;
         green_ff  <= '0;
         blue_ff   <= '0;
         pushed_ff <= 1'b0;
         case (act)
            ACT_READ: begin
               if (index_valid) begin
                  red_ff   <= read_entry[23:16];
                  green_ff <= read_entry[15:8];
                  blue_ff  <= read_entry[7:0];
               end
            end
            ACT_SPIN: pushed_ff <= spin_ok;
            default: begin
            end
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.red_out        = red_ff;
   assign rsp.green_out      = green_ff;
   assign rsp.blue_out       = blue_ff;
   assign rsp.palette_pushed = pushed_ff;

endmodule
